FILE: rtl/vsd_pkg.sv
// Types, constants and arithmetic helpers for the vector squared distance unit.
package vsd_pkg;

    // Signed exponent wide enough for squared subnormals and the zero marker
    typedef logic signed [11:0] t_exp;

    localparam logic        OP_DIST  = 1'b0;
    localparam logic        OP_MAG   = 1'b1;
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] PINF     = 32'h7F80_0000;
    localparam t_exp        EXP_ZERO = -12'sd1000;
    localparam t_exp        EMIN     = -12'sd126;
    localparam t_exp        EMAX     = 12'sd127;
    localparam t_exp        EBIAS    = 12'sd127;

    typedef struct packed {
        logic nan;
        logic inf;
    } t_spec;

    typedef struct packed {
        logic [27:0] sum;
        logic [7:0]  eb;
    } t_sub_sum;

    typedef struct packed {
        logic [27:0] n;
        t_exp        e;
        logic        zero;
    } t_sub_norm;

    typedef struct packed {
        logic [23:0] m;
        t_exp        e;
        logic        zero;
        logic        ovf;
    } t_dval;

    typedef struct packed {
        logic [47:0] p;
        t_exp        e;
    } t_prod;

    typedef struct packed {
        logic [51:0] s;
        t_exp        e;
    } t_pass_sum;

    typedef struct packed {
        logic [30:0] bits;
        logic        ovf;
    } t_pass_res;

    // Classify a - b for NaN and infinity
    function automatic t_spec sub_spec(input logic [31:0] a, input logic [31:0] b);
        logic  a_nan, b_nan, a_inf, b_inf;
        t_spec r;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        r.nan = a_nan || b_nan || (a_inf && b_inf && (a[31] == b[31]));
        r.inf = !r.nan && (a_inf || b_inf);
        return r;
    endfunction

    // Swap, align and add or subtract magnitudes of a - b; the sign is dropped since it is squared
    function automatic t_sub_sum sub_align(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea, eb, ebig, esm, d;
        logic [23:0] ma, mb, mbig, msm;
        logic [4:0]  sh;
        logic [53:0] ext;
        logic [26:0] sm;
        t_sub_sum    r;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (a[30:0] >= b[30:0]) begin
            ebig = ea; mbig = ma; esm = eb; msm = mb;
        end else begin
            ebig = eb; mbig = mb; esm = ea; msm = ma;
        end
        d   = ebig - esm;
        sh  = (d > 8'd31) ? 5'd31 : d[4:0];
        ext = {msm, 3'b000, 27'd0} >> sh;
        sm  = ext[53:27] | {26'd0, |ext[26:0]};
        if (a[31] == b[31]) begin
            r.sum = {1'b0, mbig, 3'b000} - {1'b0, sm};
        end else begin
            r.sum = {1'b0, mbig, 3'b000} + {1'b0, sm};
        end
        r.eb = ebig;
        return r;
    endfunction

    // Normalize the difference so bit 27 is set, five shift steps
    function automatic t_sub_norm sub_norm(input t_sub_sum x);
        logic [27:0] n;
        t_exp        e;
        t_sub_norm   r;
        n = x.sum;
        e = $signed({4'b0000, x.eb}) + EMIN;
        if (n[27:12] == 16'd0) begin n = n << 16; e = e - 12'sd16; end
        if (n[27:20] == 8'd0)  begin n = n << 8;  e = e - 12'sd8;  end
        if (n[27:24] == 4'd0)  begin n = n << 4;  e = e - 12'sd4;  end
        if (n[27:26] == 2'd0)  begin n = n << 2;  e = e - 12'sd2;  end
        if (!n[27])            begin n = n << 1;  e = e - 12'sd1;  end
        r.n    = n;
        r.e    = e;
        r.zero = (x.sum == 28'd0);
        return r;
    endfunction

    // Round the normalized difference to 24 bits, nearest even
    function automatic t_dval sub_round(input t_sub_norm x);
        logic [23:0] m;
        logic [24:0] mr;
        logic        up;
        t_exp        e;
        t_dval       r;
        m  = x.n[27:4];
        up = x.n[3] && ((|x.n[2:0]) || m[0]);
        mr = {1'b0, m} + {24'd0, up};
        e  = x.e;
        if (mr[24]) begin
            m = 24'h80_0000;
            e = e + 12'sd1;
        end else begin
            m = mr[23:0];
        end
        r.m    = m;
        r.e    = e;
        r.zero = x.zero;
        r.ovf  = !x.zero && (e > EMAX);
        return r;
    endfunction

    // Bring a square to a 48-bit mantissa with its top bit set
    function automatic t_prod prod_norm(input logic [47:0] p, input t_exp e, input logic zero);
        t_prod r;
        if (zero) begin
            r.p = 48'd0;
            r.e = EXP_ZERO;
        end else if (p[47]) begin
            r.p = p;
            r.e = e + e + 12'sd1;
        end else begin
            r.p = p << 1;
            r.e = e + e;
        end
        return r;
    endfunction

    // Align the exact square against the accumulator and add
    function automatic t_pass_sum pass_add(input logic [30:0] acc, input t_prod q);
        logic [47:0]  xa, big, sm;
        t_exp         ea, ebig, esm, dd;
        logic [5:0]   sh;
        logic [101:0] ext;
        logic [50:0]  sm51;
        t_pass_sum    r;
        xa = {acc[30:23] != 8'd0, acc[22:0], 24'd0};
        ea = $signed({4'b0000, (acc[30:23] == 8'd0) ? 8'd1 : acc[30:23]}) - EBIAS;
        if (q.e > ea) begin
            big = q.p; ebig = q.e; sm = xa; esm = ea;
        end else begin
            big = xa; ebig = ea; sm = q.p; esm = q.e;
        end
        dd   = ebig - esm;
        sh   = (dd > 12'sd63) ? 6'd63 : dd[5:0];
        ext  = {sm, 3'b000, 51'd0} >> sh;
        sm51 = ext[101:51] | {50'd0, |ext[50:0]};
        r.s  = {1'b0, big, 3'b000} + {1'b0, sm51};
        r.e  = ebig;
        return r;
    endfunction

    // Round a positive sum to binary32, subnormals kept
    function automatic t_pass_res pass_round(input t_pass_sum x);
        logic [50:0]  v;
        logic [101:0] ext;
        logic [23:0]  m;
        logic [24:0]  mr;
        logic [5:0]   sh;
        logic         up;
        t_exp         e, k, f;
        t_pass_res    r;
        if (x.s[51]) begin
            v = x.s[51:1] | {50'd0, x.s[0]};
            e = x.e + 12'sd1;
        end else begin
            v = x.s[50:0];
            e = x.e;
        end
        if (e < EMIN) begin
            k   = EMIN - e;
            sh  = (k > 12'sd63) ? 6'd63 : k[5:0];
            ext = {v, 51'd0} >> sh;
            v   = ext[101:51] | {50'd0, |ext[50:0]};
            e   = EMIN;
        end
        m  = v[50:27];
        up = v[26] && ((|v[25:0]) || m[0]);
        mr = {1'b0, m} + {24'd0, up};
        if (mr[24]) begin
            m = 24'h80_0000;
            e = e + 12'sd1;
        end else begin
            m = mr[23:0];
        end
        f      = m[23] ? (e + EBIAS) : 12'sd0;
        r.bits = {f[7:0], m[22:0]};
        r.ovf  = m[23] && (e > EMAX);
        return r;
    endfunction

endpackage

FILE: rtl/vector3_squared_distance_unit.sv
// Pipelined binary32 squared distance / squared magnitude of 3-component vectors.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_opcode, i_a_x..i_a_z, i_b_x..i_b_z
//  out     | output    | o_out_valid / i_out_ready  | o_sum_of_squares
//
// Ten register stages: subtract (align/add, normalize, round), square, then
// three add-and-round passes of two stages each.
// One transaction per cycle is taken and delivered while the output is drained.
// Each stage holds when it is full and the stage after it holds; bubbles collapse.
// Reset clears only the stage valid bits.
module vector3_squared_distance_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sum_of_squares
);

    localparam int unsigned NSTG = 10;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [31:0] a_in [3];
    logic [31:0] b_in [3];

    vsd_pkg::t_sub_sum  r1_sum [3];
    vsd_pkg::t_sub_norm r2_n   [3];
    vsd_pkg::t_dval     r3_d   [3];
    logic [47:0]        r4_p   [3];
    vsd_pkg::t_exp      r4_e   [3];
    logic               r4_z   [3];
    vsd_pkg::t_spec     r_spec [NSTG-1];
    vsd_pkg::t_spec     n_spec1;

    vsd_pkg::t_prod     r5_q  [2];
    vsd_pkg::t_pass_sum r5_s;
    vsd_pkg::t_prod     r6_q  [2];
    logic [30:0]        r6_acc;
    vsd_pkg::t_pass_sum r7_s;
    vsd_pkg::t_prod     r7_q;
    vsd_pkg::t_prod     r8_q;
    logic [30:0]        r8_acc;
    vsd_pkg::t_pass_sum r9_s;
    logic [31:0]        r_res;

    vsd_pkg::t_pass_res pr6, pr8, pr10;
    vsd_pkg::t_spec     spc [3];

    // Chain the stage enables from the output back
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_ready       = en[0];
    assign o_out_valid      = r_vld[NSTG-1];
    assign o_sum_of_squares = r_res;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = NSTG - 1; k > 0; k--) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
        end
    end

    // Zero vector b in magnitude mode and classify the operands
    always_comb begin
        a_in[0] = i_a_x;
        a_in[1] = i_a_y;
        a_in[2] = i_a_z;
        b_in[0] = (i_opcode == vsd_pkg::OP_MAG) ? 32'd0 : i_b_x;
        b_in[1] = (i_opcode == vsd_pkg::OP_MAG) ? 32'd0 : i_b_y;
        b_in[2] = (i_opcode == vsd_pkg::OP_MAG) ? 32'd0 : i_b_z;
        for (int c = 0; c < 3; c++) begin
            spc[c] = vsd_pkg::sub_spec(a_in[c], b_in[c]);
        end
        n_spec1.nan = spc[0].nan || spc[1].nan || spc[2].nan;
        n_spec1.inf = spc[0].inf || spc[1].inf || spc[2].inf;
    end

    assign pr6  = vsd_pkg::pass_round(r5_s);
    assign pr8  = vsd_pkg::pass_round(r7_s);
    assign pr10 = vsd_pkg::pass_round(r9_s);

    // Stages 1 to 4: differences and squares
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int c = 0; c < 3; c++) begin
                r1_sum[c] <= vsd_pkg::sub_align(a_in[c], b_in[c]);
            end
            r_spec[0] <= n_spec1;
        end
        if (en[1]) begin
            for (int c = 0; c < 3; c++) begin
                r2_n[c] <= vsd_pkg::sub_norm(r1_sum[c]);
            end
            r_spec[1] <= r_spec[0];
        end
        if (en[2]) begin
            for (int c = 0; c < 3; c++) begin
                r3_d[c] <= vsd_pkg::sub_round(r2_n[c]);
            end
            r_spec[2] <= r_spec[1];
        end
        if (en[3]) begin
            for (int c = 0; c < 3; c++) begin
                r4_p[c] <= r3_d[c].m * r3_d[c].m;
                r4_e[c] <= r3_d[c].e;
                r4_z[c] <= r3_d[c].zero;
            end
            r_spec[3].nan <= r_spec[2].nan;
            r_spec[3].inf <= r_spec[2].inf || r3_d[0].ovf || r3_d[1].ovf || r3_d[2].ovf;
        end

        // Stages 5 to 10: fold x, y, z squares into the accumulator
        if (en[4]) begin
            r5_s    <= vsd_pkg::pass_add(31'd0, vsd_pkg::prod_norm(r4_p[0], r4_e[0], r4_z[0]));
            r5_q[0] <= vsd_pkg::prod_norm(r4_p[1], r4_e[1], r4_z[1]);
            r5_q[1] <= vsd_pkg::prod_norm(r4_p[2], r4_e[2], r4_z[2]);
            r_spec[4] <= r_spec[3];
        end
        if (en[5]) begin
            r6_acc        <= pr6.bits;
            r6_q          <= r5_q;
            r_spec[5].nan <= r_spec[4].nan;
            r_spec[5].inf <= r_spec[4].inf || pr6.ovf;
        end
        if (en[6]) begin
            r7_s      <= vsd_pkg::pass_add(r6_acc, r6_q[0]);
            r7_q      <= r6_q[1];
            r_spec[6] <= r_spec[5];
        end
        if (en[7]) begin
            r8_acc        <= pr8.bits;
            r8_q          <= r7_q;
            r_spec[7].nan <= r_spec[6].nan;
            r_spec[7].inf <= r_spec[6].inf || pr8.ovf;
        end
        if (en[8]) begin
            r9_s      <= vsd_pkg::pass_add(r8_acc, r8_q);
            r_spec[8] <= r_spec[7];
        end
        if (en[9]) begin
            if (r_spec[8].nan) begin
                r_res <= vsd_pkg::QNAN;
            end else if (r_spec[8].inf || pr10.ovf) begin
                r_res <= vsd_pkg::PINF;
            end else begin
                r_res <= {1'b0, pr10.bits};
            end
        end
    end

endmodule

FILE: rtl/vsd_checker.sv
// Port-level checks for the vector squared distance unit, bound to the top level.
module vsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_sum_of_squares
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sum_of_squares))
        else $error("stalled result dropped or changed");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // Accept input whenever the output side can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with a free pipeline");

    // Return NaN only in canonical form
    a_qnan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sum_of_squares[30:23] == 8'hFF) && (o_sum_of_squares[22:0] != 23'd0)
        |-> o_sum_of_squares == vsd_pkg::QNAN)
        else $error("non-canonical NaN");

endmodule

bind vector3_squared_distance_unit vsd_checker u_vsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sum_of_squares (o_sum_of_squares)
);

FILE: verif/vector3_squared_distance_checker.sv
// Checker for the vector squared distance unit: predicts each result and compares it.
module vector3_squared_distance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_sum_of_squares,
    output int          o_errors,
    output int          o_pending
);

    logic [31:0] sum_queue[$];

    // Widen a binary32 pattern to a real, exactly
    function automatic real fp32_to_real(input logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF) begin
            if (f[22:0] != 23'd0) r = $bitstoreal(64'h7FF8_0000_0000_0000);
            else r = $bitstoreal({f[31], 11'h7FF, 52'd0});
        end else if (f[30:23] == 8'd0) begin
            r = real'(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
            if (f[31]) r = -r;
        end else begin
            r = $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0});
        end
        return r;
    endfunction

    // Narrow a real to binary32, round to nearest even, subnormals kept
    function automatic logic [31:0] real_to_fp32(input real d);
        logic [63:0] b, sig, r;
        logic [31:0] v;
        int          ex, t;
        logic        guard, sticky, up;
        b = $realtobits(d);
        if (b[62:52] == 11'h7FF) begin
            if (b[51:0] != 52'd0) return vsd_pkg::QNAN;
            return {b[63], vsd_pkg::PINF[30:0]};
        end
        if (b[62:52] == 11'd0) return {b[63], 31'd0};
        ex  = int'(b[62:52]) - 1023;
        sig = {11'd0, 1'b1, b[51:0]};
        if (ex > 127) return {b[63], vsd_pkg::PINF[30:0]};
        if (ex >= -126) begin
            guard  = sig[28];
            sticky = |sig[27:0];
            up     = guard && (sticky || sig[29]);
            v      = {1'b0, 8'(ex + 127), sig[51:29]} + {31'd0, up};
        end else begin
            t = -97 - ex;
            if (t > 55) begin
                v = 32'd0;
            end else begin
                r      = sig >> t;
                guard  = sig[t - 1];
                sticky = (sig & ((64'd1 << (t - 1)) - 64'd1)) != 64'd0;
                up     = guard && (sticky || r[0]);
                v      = r[31:0] + {31'd0, up};
            end
        end
        if (v >= vsd_pkg::PINF) v = vsd_pkg::PINF;
        return {b[63], v[30:0]};
    endfunction

    // Fused x*y + c with one rounding, via round-to-odd in double
    function automatic logic [31:0] fp32_fma(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] c);
        real         p, cd, s, t, e;
        logic [63:0] b;
        p  = fp32_to_real(x) * fp32_to_real(y);
        cd = fp32_to_real(c);
        s  = p + cd;
        if (!(s - s == 0.0)) return real_to_fp32(s);
        t = s - p;
        e = (p - (s - t)) + (cd - t);
        if (e != 0.0) begin
            b = $realtobits(s);
            if (!b[0]) begin
                b = ((s > 0.0) == (e > 0.0)) ? b + 64'd1 : b - 64'd1;
                s = $bitstoreal(b);
            end
        end
        return real_to_fp32(s);
    endfunction

    // Predict one squared distance or magnitude
    function automatic logic [31:0] predict_sum(input logic op,
                                                input logic [31:0] ax, ay, az, bx, by, bz);
        logic [31:0] dx, dy, dz, acc, ux, uy, uz;
        ux  = (op == vsd_pkg::OP_MAG) ? 32'd0 : bx;
        uy  = (op == vsd_pkg::OP_MAG) ? 32'd0 : by;
        uz  = (op == vsd_pkg::OP_MAG) ? 32'd0 : bz;
        dx  = real_to_fp32(fp32_to_real(ax) - fp32_to_real(ux));
        dy  = real_to_fp32(fp32_to_real(ay) - fp32_to_real(uy));
        dz  = real_to_fp32(fp32_to_real(az) - fp32_to_real(uz));
        acc = real_to_fp32(fp32_to_real(dx) * fp32_to_real(dx));
        acc = fp32_fma(dy, dy, acc);
        acc = fp32_fma(dz, dz, acc);
        if (acc[30:23] == 8'hFF && acc[22:0] != 23'd0) acc = vsd_pkg::QNAN;
        return acc;
    endfunction

    assign o_pending = sum_queue.size();

    // Record accepted inputs and compare delivered results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                sum_queue.push_back(predict_sum(i_opcode, i_a_x, i_a_y, i_a_z,
                                                i_b_x, i_b_y, i_b_z));
            if (i_out_valid && i_out_ready) begin
                if (sum_queue.size() == 0) begin
                    $error("sum_of_squares: unexpected transaction, actual %h",
                           i_sum_of_squares);
                    o_errors <= o_errors + 1;
                end else if (sum_queue[0] !== i_sum_of_squares) begin
                    $error("sum_of_squares: expected %h actual %h",
                           sum_queue[0], i_sum_of_squares);
                    o_errors <= o_errors + 1;
                    void'(sum_queue.pop_front());
                end else begin
                    void'(sum_queue.pop_front());
                end
            end
        end
    end

endmodule

FILE: verif/tb_vector3_squared_distance_unit.sv
// Testbench top for the vector squared distance unit: stimulus and verdict.
module tb_vector3_squared_distance_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = vsd_pkg::OP_DIST;
    logic [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_sum_of_squares;
    int          errors, pending;
    logic        busy_run = 1'b0;

    vector3_squared_distance_unit dut (.*);

    vector3_squared_distance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_opcode(i_opcode),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sum_of_squares(o_sum_of_squares), .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // Stall the output side at random, except during the busy stretch
    always @(posedge i_clk)
        i_out_ready <= busy_run ? 1'b1 : ($urandom_range(99) >= 34);

    // Hand one transaction to the block and wait for it to be taken
    task automatic send_vectors(input logic op, input logic [31:0] ax, ay, az, bx, by, bz);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_a_x <= ax; i_a_y <= ay; i_a_z <= az;
        i_b_x <= bx; i_b_y <= by; i_b_z <= bz;
        do @(posedge i_clk); while (!o_in_ready);
        if (!busy_run) begin
            if ($urandom_range(99) < 34) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < 34);
            end
        end
    endtask

    // Pick a component value, weighted toward ranges that give real results
    function automatic logic [31:0] pick_component();
        logic [31:0] specials[8];
        int          kind;
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000};
        kind = $urandom_range(9);
        if (kind <= 1) return $urandom;
        if (kind == 2) return specials[$urandom_range(7)];
        if (kind == 8) return {1'($urandom), 8'($urandom_range(20)), 23'($urandom)};
        if (kind == 9) return {1'($urandom), 8'($urandom_range(180, 254)), 23'($urandom)};
        return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    endfunction

    // Second vector component: often close to the first to force cancellation
    function automatic logic [31:0] pick_partner(input logic [31:0] a);
        if ($urandom_range(99) < 30) return a ^ (32'($urandom) & 32'h0000_00FF);
        if ($urandom_range(99) < 5) return a ^ 32'h8000_0000;
        return pick_component();
    endfunction

    initial begin
        logic [31:0] ax, ay, az;
        logic        op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, signed zeros, extremes, infinities, NaNs, overflow
        send_vectors(vsd_pkg::OP_DIST, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h8000_0000, 32'h0, 32'h8000_0000,
                     32'h0, 32'h8000_0000, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vectors(vsd_pkg::OP_DIST, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000,
                     32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
        send_vectors(vsd_pkg::OP_DIST, 32'h7F80_0000, 32'h0, 32'h0,
                     32'h7F80_0000, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h7F80_0000, 32'h0, 32'h0,
                     32'hFF80_0000, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'hFF80_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h7FC0_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h0, 32'hFF80_0001, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h0, 32'h0, 32'h7F80_0000,
                     32'h0, 32'h7FFF_FFFF, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                     32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h7F7F_FFFF, 32'h0, 32'h0,
                     32'hFF7F_FFFF, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h5F80_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
                     32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'h1F80_0000, 32'h1F00_0000, 32'h2000_0000,
                     32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h0080_0000, 32'h0, 32'h0,
                     32'h007F_FFFF, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h3F80_0001, 32'h3F80_0000, 32'h0, 32'h3F80_0000,
                     32'h3F7F_FFFF, 32'h0);
        send_vectors(vsd_pkg::OP_MAG, 32'h4B80_0001, 32'h3F80_0000, 32'h3380_0000,
                     32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h0, 32'h0, 32'h0);
        send_vectors(vsd_pkg::OP_DIST, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);

        // Random: mixed ranges, with a burst of back-to-back traffic
        for (int n = 0; n < 650; n++) begin
            busy_run <= (n >= 250 && n < 370);
            op = ($urandom_range(99) < 30) ? vsd_pkg::OP_MAG : vsd_pkg::OP_DIST;
            ax = pick_component();
            ay = pick_component();
            az = pick_component();
            send_vectors(op, ax, ay, az, pick_partner(ax), pick_partner(ay), pick_partner(az));
        end
        i_in_valid <= 1'b0;
        busy_run   <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 100000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
